// ===== rtl/rtp_pkg.sv =====
// shared types, constants and angle table for the two-point rigid transform
package rtp_pkg;

  localparam int ROTATION_STAGES = 16;
  localparam int COORD_BITS      = 32;
  localparam int N_CELLS         = (ROTATION_STAGES > 32) ? 32 : ROTATION_STAGES;
  localparam int GUARD_BITS      = 14;
  // datapath width: Q16.30 plus sign after fold plus cordic growth
  localparam int DW              = 50;
  localparam int ZW              = 34;
  localparam int PW              = DW + 17;
  localparam int RW              = DW + 1;
  localparam int GAIN_HI         = 39796;
  localparam int GAIN_LO         = 60840;
  localparam int POST_STAGES     = 3;
  localparam int LATENCY         = 1 + N_CELLS + POST_STAGES;

  localparam logic signed [RW-1:0] SAT_HI = (RW'(1) <<< (COORD_BITS - 1)) - RW'(1);
  localparam logic signed [RW-1:0] SAT_LO = -SAT_HI - RW'(1);

  typedef struct packed {
    logic signed [31:0] base_x;
    logic signed [31:0] base_y;
    logic signed [15:0] base_heading;
    logic signed [31:0] first_x;
    logic signed [31:0] first_y;
    logic signed [31:0] second_x;
    logic signed [31:0] second_y;
  } req_t;

  typedef struct packed {
    logic signed [31:0] global_first_x;
    logic signed [31:0] global_first_y;
    logic signed [31:0] global_second_x;
    logic signed [31:0] global_second_y;
  } res_t;

  typedef struct packed {
    logic signed [DW-1:0] x1;
    logic signed [DW-1:0] y1;
    logic signed [DW-1:0] x2;
    logic signed [DW-1:0] y2;
    logic signed [ZW-1:0] z;
    logic signed [31:0]   bx;
    logic signed [31:0]   by;
  } stage_t;

  // atan(2^-i) in units of 2^32 per turn
  function automatic logic signed [ZW-1:0] atan_lut(input logic [4:0] i);
    logic signed [ZW-1:0] a;
    case (i)
      5'd0:  a = ZW'(536870912);
      5'd1:  a = ZW'(316933406);
      5'd2:  a = ZW'(167458907);
      5'd3:  a = ZW'(85004756);
      5'd4:  a = ZW'(42667331);
      5'd5:  a = ZW'(21354465);
      5'd6:  a = ZW'(10679838);
      5'd7:  a = ZW'(5340245);
      5'd8:  a = ZW'(2670163);
      5'd9:  a = ZW'(1335087);
      5'd10: a = ZW'(667544);
      5'd11: a = ZW'(333772);
      5'd12: a = ZW'(166886);
      5'd13: a = ZW'(83443);
      5'd14: a = ZW'(41722);
      5'd15: a = ZW'(20861);
      5'd16: a = ZW'(10430);
      5'd17: a = ZW'(5215);
      5'd18: a = ZW'(2608);
      5'd19: a = ZW'(1304);
      5'd20: a = ZW'(652);
      5'd21: a = ZW'(326);
      5'd22: a = ZW'(163);
      5'd23: a = ZW'(81);
      5'd24: a = ZW'(41);
      5'd25: a = ZW'(20);
      5'd26: a = ZW'(10);
      5'd27: a = ZW'(5);
      5'd28: a = ZW'(3);
      5'd29: a = ZW'(1);
      5'd30: a = ZW'(1);
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// ===== rtl/rtp_cell.sv =====
// one cordic micro-rotation cell applied to both points of a request
module rtp_cell (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  logic [4:0]             idx_i,
  input  rtp_pkg::stage_t        d_i,
  output logic                   valid_o,
  output rtp_pkg::stage_t        d_o
);

  logic            valid_q;
  rtp_pkg::stage_t d_d, d_q;
  logic            up;
  logic signed [rtp_pkg::ZW-1:0] ang;

  always_comb begin
    up  = !d_i.z[rtp_pkg::ZW-1];
    ang = rtp_pkg::atan_lut(idx_i);
    d_d = d_i;
    if (up) begin
      d_d.x1 = d_i.x1 - (d_i.y1 >>> idx_i);
      d_d.y1 = d_i.y1 + (d_i.x1 >>> idx_i);
      d_d.x2 = d_i.x2 - (d_i.y2 >>> idx_i);
      d_d.y2 = d_i.y2 + (d_i.x2 >>> idx_i);
      d_d.z  = d_i.z - ang;
    end else begin
      d_d.x1 = d_i.x1 + (d_i.y1 >>> idx_i);
      d_d.y1 = d_i.y1 - (d_i.x1 >>> idx_i);
      d_d.x2 = d_i.x2 + (d_i.y2 >>> idx_i);
      d_d.y2 = d_i.y2 - (d_i.x2 >>> idx_i);
      d_d.z  = d_i.z + ang;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    d_q <= d_d;
  end

  assign valid_o = valid_q;
  assign d_o     = d_q;

endmodule

// ===== rtl/rtp_post.sv =====
// gain correction, rounding to q16.16, base offset and saturation for one coordinate
module rtp_post (
  input  logic                           clk_i,
  input  logic signed [rtp_pkg::DW-1:0]  v_i,
  input  logic signed [31:0]             base_i,
  output logic signed [31:0]             coord_o
);

  localparam logic signed [rtp_pkg::PW-1:0] KHI = rtp_pkg::PW'(rtp_pkg::GAIN_HI);
  localparam logic signed [rtp_pkg::PW-1:0] KLO = rtp_pkg::PW'(rtp_pkg::GAIN_LO);
  localparam logic signed [rtp_pkg::DW-1:0] HALF =
    rtp_pkg::DW'(1) <<< (rtp_pkg::GUARD_BITS - 1);

  logic signed [rtp_pkg::PW-1:0] hi_q, lo_q, hi_d, lo_d, sum;
  logic signed [rtp_pkg::DW-1:0] g_d, g_q, gr;
  logic signed [rtp_pkg::RW-1:0] r;
  logic signed [31:0]            b1_q, b2_q, out_d, out_q;

  always_comb begin
    hi_d = rtp_pkg::PW'(v_i) * KHI;
    lo_d = rtp_pkg::PW'(v_i) * KLO;
    sum  = hi_q + (lo_q >>> 16);
    g_d  = rtp_pkg::DW'(sum >>> 16);
    gr   = (g_q + HALF) >>> rtp_pkg::GUARD_BITS;
    r    = {gr[rtp_pkg::DW-1], gr} + {{(rtp_pkg::RW-32){b2_q[31]}}, b2_q};
    if (r > rtp_pkg::SAT_HI) begin
      out_d = rtp_pkg::SAT_HI[31:0];
    end else if (r < rtp_pkg::SAT_LO) begin
      out_d = rtp_pkg::SAT_LO[31:0];
    end else begin
      out_d = r[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    hi_q  <= hi_d;
    lo_q  <= lo_d;
    b1_q  <= base_i;
    g_q   <= g_d;
    b2_q  <= b1_q;
    out_q <= out_d;
  end

  assign coord_o = out_q;

endmodule

// ===== rtl/rigid_transform_two_points_core.sv =====
// top level: quadrant fold, chain of cordic cells, gain and offset stages
// Rotates two points by a base heading (cordic, one cell per micro-rotation) and adds
// the base position. One request is taken every clock cycle, busy_o stays low, and each
// result appears on res_o with res_valid_o high for one cycle, after its start has passed
// one fold register, one register per cordic cell, then the gain multiply, gain sum and
// round/offset/saturate registers. The receiver has no way to stall, so results must be
// taken when strobed.
module rigid_transform_two_points_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  rtp_pkg::req_t req_i,
  output logic          busy_o,
  output logic          res_valid_o,
  output rtp_pkg::res_t res_o
);

  localparam int N = rtp_pkg::N_CELLS;
  localparam int DW = rtp_pkg::DW;

  logic                accept;
  logic                fold_valid_q;
  rtp_pkg::stage_t     fold_d, fold_q;
  logic signed [16:0]  h;
  logic                neg;
  logic signed [DW-1:0] x1w, y1w, x2w, y2w;

  logic                cv [N+1];
  rtp_pkg::stage_t     cd [N+1];
  logic [rtp_pkg::POST_STAGES-1:0] pv_q;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_comb begin
    h   = {req_i.base_heading[15], req_i.base_heading};
    neg = 1'b0;
    if (h > 17'sd16384) begin
      neg = 1'b1;
      h   = h - 17'sd32768;
    end else if (h < -17'sd16384) begin
      neg = 1'b1;
      h   = h + 17'sd32768;
    end
    x1w = DW'(req_i.first_x)  <<< rtp_pkg::GUARD_BITS;
    y1w = DW'(req_i.first_y)  <<< rtp_pkg::GUARD_BITS;
    x2w = DW'(req_i.second_x) <<< rtp_pkg::GUARD_BITS;
    y2w = DW'(req_i.second_y) <<< rtp_pkg::GUARD_BITS;
    fold_d.x1 = neg ? -x1w : x1w;
    fold_d.y1 = neg ? -y1w : y1w;
    fold_d.x2 = neg ? -x2w : x2w;
    fold_d.y2 = neg ? -y2w : y2w;
    fold_d.z  = {{(rtp_pkg::ZW-33){h[16]}}, h, 16'b0};
    fold_d.bx = req_i.base_x;
    fold_d.by = req_i.base_y;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fold_valid_q <= 1'b0;
      pv_q         <= '0;
    end else begin
      fold_valid_q <= accept;
      pv_q         <= {pv_q[rtp_pkg::POST_STAGES-2:0], cv[N]};
    end
  end

  always_ff @(posedge clk_i) begin
    fold_q <= fold_d;
  end

  assign cv[0] = fold_valid_q;
  assign cd[0] = fold_q;

  for (genvar k = 0; k < N; k++) begin : g_cell
    rtp_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (cv[k]),
      .idx_i   (5'(k)),
      .d_i     (cd[k]),
      .valid_o (cv[k+1]),
      .d_o     (cd[k+1])
    );
  end

  rtp_post u_post_x1 (
    .clk_i(clk_i), .v_i(cd[N].x1), .base_i(cd[N].bx), .coord_o(res_o.global_first_x)
  );
  rtp_post u_post_y1 (
    .clk_i(clk_i), .v_i(cd[N].y1), .base_i(cd[N].by), .coord_o(res_o.global_first_y)
  );
  rtp_post u_post_x2 (
    .clk_i(clk_i), .v_i(cd[N].x2), .base_i(cd[N].bx), .coord_o(res_o.global_second_x)
  );
  rtp_post u_post_y2 (
    .clk_i(clk_i), .v_i(cd[N].y2), .base_i(cd[N].by), .coord_o(res_o.global_second_y)
  );

  assign res_valid_o = pv_q[rtp_pkg::POST_STAGES-1];

  a_result_has_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(accept, rtp_pkg::LATENCY))
    else $error("result strobe without a matching request");

  a_request_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##(rtp_pkg::LATENCY) res_valid_o)
    else $error("request lost in the pipeline");

  a_chain_tracks_fold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cv[N] |-> $past(fold_valid_q, N))
    else $error("cell chain valid out of step with fold stage");

endmodule

// ===== tb/tb.sv =====
// testbench for the two-point rigid transform checked against a cordic predictor
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rtp_pkg::*;

  localparam int    GUARD       = 14;
  localparam longint GAIN_Q32   = 64'd2608131496;
  localparam longint GAIN_UPPER = GAIN_Q32 >>> 16;
  localparam longint GAIN_LOWER = GAIN_Q32 & 64'hFFFF;
  localparam int    STALL_LIMIT = 2000;
  localparam int    RANDOM_REQS = 950;

  localparam logic signed [31:0] C_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] C_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] C_ONE = 32'sh0001_0000;

  typedef enum int {PICK_SCALED, PICK_FULL, PICK_CORNER} coord_pick_e;

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  start_i = 1'b0;
  req_t  req_i = '0;
  logic  busy_o;
  logic  res_valid_o;
  res_t  res_o;

  req_t   pending_q[$];
  res_t   expected_q[$];
  int     total_reqs;
  int     sent_cnt = 0;
  int     mismatch_cnt = 0;
  int     quiet_cycles = 0;

  // angle of each micro-rotation, 2^32 per turn
  longint turn_angle [0:31] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1, 1, 0
  };

  rigid_transform_two_points_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .req_i      (req_i),
    .busy_o     (busy_o),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic longint scale_gain(input longint v);
    longint upper;
    longint lower;
    upper = v * GAIN_UPPER;
    lower = (v * GAIN_LOWER) >>> 16;
    return (upper + lower) >>> 16;
  endfunction

  function automatic logic signed [31:0] round_offset(input longint v, input longint base);
    longint r;
    longint hi_lim;
    longint lo_lim;
    hi_lim = (longint'(1) <<< (COORD_BITS - 1)) - 1;
    lo_lim = -hi_lim - 1;
    r = ((v + (longint'(1) <<< (GUARD - 1))) >>> GUARD) + base;
    if (r > hi_lim) r = hi_lim;
    if (r < lo_lim) r = lo_lim;
    return r[31:0];
  endfunction

  function automatic void rotate_point(input longint px, input longint py, input int heading,
                                       input longint bx, input longint by,
                                       output logic signed [31:0] ox,
                                       output logic signed [31:0] oy);
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    int     h;
    int     n;
    int     i;
    x = px <<< GUARD;
    y = py <<< GUARD;
    h = heading;
    n = (ROTATION_STAGES > 32) ? 32 : ROTATION_STAGES;
    // fold into [-pi/2, pi/2] by a half turn
    if (h > 16384) begin
      x = -x;
      y = -y;
      h = h - 32768;
    end else if (h < -16384) begin
      x = -x;
      y = -y;
      h = h + 32768;
    end
    z = longint'(h) * 65536;
    for (i = 0; i < n; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - turn_angle[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + turn_angle[i];
      end
    end
    ox = round_offset(scale_gain(x), bx);
    oy = round_offset(scale_gain(y), by);
  endfunction

  function automatic res_t transform_pair(input req_t r);
    res_t o;
    rotate_point(longint'(r.first_x), longint'(r.first_y), int'(r.base_heading),
                 longint'(r.base_x), longint'(r.base_y), o.global_first_x, o.global_first_y);
    rotate_point(longint'(r.second_x), longint'(r.second_y), int'(r.base_heading),
                 longint'(r.base_x), longint'(r.base_y), o.global_second_x, o.global_second_y);
    return o;
  endfunction

  function automatic logic signed [31:0] rand_coord();
    coord_pick_e pick;
    int          roll;
    roll = $urandom_range(0, 9);
    pick = (roll < 6) ? PICK_SCALED : (roll < 8) ? PICK_FULL : PICK_CORNER;
    case (pick)
      PICK_SCALED: return $signed($urandom) >>> $urandom_range(4, 24);
      PICK_FULL:   return $urandom;
      default: begin
        case ($urandom_range(0, 5))
          0: return C_MAX;
          1: return C_MIN;
          2: return '0;
          3: return -32'sd1;
          4: return C_ONE;
          default: return -C_ONE;
        endcase
      end
    endcase
  endfunction

  function automatic logic signed [15:0] rand_heading();
    if ($urandom_range(0, 7) != 0) return 16'($urandom_range(0, 65535));
    case ($urandom_range(0, 6))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return 16'sd16384;
      3: return -16'sd16384;
      4: return 16'sd16385;
      5: return -16'sd16385;
      default: return '0;
    endcase
  endfunction

  task automatic add_req(input logic signed [31:0] bx, input logic signed [31:0] by,
                         input logic signed [15:0] h,
                         input logic signed [31:0] fx, input logic signed [31:0] fy,
                         input logic signed [31:0] sx, input logic signed [31:0] sy);
    req_t r;
    r.base_x       = bx;
    r.base_y       = by;
    r.base_heading = h;
    r.first_x      = fx;
    r.first_y      = fy;
    r.second_x     = sx;
    r.second_y     = sy;
    pending_q.push_back(r);
  endtask

  task automatic check_coord(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (want !== got) begin
      if (mismatch_cnt < 10)
        $display("mismatch %s: expected %0d (%h) got %0d (%h)", name, want, want, got, got);
      mismatch_cnt++;
    end
  endtask

  // driver: a request stays on the port until it is taken
  always @(posedge clk_i) begin : drive
    int gap_pct;
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      if (start_i && !busy_o) begin
        expected_q.push_back(transform_pair(req_i));
        void'(pending_q.pop_front());
        sent_cnt++;
      end
      case ((sent_cnt * 3) / total_reqs)
        0: gap_pct = 31;
        1: gap_pct = 66;
        default: gap_pct = 0;
      endcase
      if (!(start_i && busy_o)) begin
        if (pending_q.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
          start_i <= 1'b1;
          req_i   <= pending_q[0];
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : monitor
    res_t want;
    if (rst_ni && res_valid_o) begin
      if (expected_q.size() == 0) begin
        if (mismatch_cnt < 10) $display("unexpected result %h", res_o);
        mismatch_cnt++;
      end else begin
        want = expected_q.pop_front();
        check_coord("global_first_x", want.global_first_x, res_o.global_first_x);
        check_coord("global_first_y", want.global_first_y, res_o.global_first_y);
        check_coord("global_second_x", want.global_second_x, res_o.global_second_x);
        check_coord("global_second_y", want.global_second_y, res_o.global_second_y);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((rst_ni && start_i && !busy_o) || (rst_ni && res_valid_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int k;

    add_req('0, '0, '0, '0, '0, '0, '0);
    add_req('0, '0, 16'sd16384, C_ONE, '0, '0, C_ONE);
    add_req('0, '0, -16'sd16384, C_ONE, '0, '0, C_ONE);
    // minus pi folds to an exact half turn
    add_req(C_ONE, -C_ONE, -16'sd32768, C_ONE, 32'sd12345, C_MIN, C_MAX);
    add_req('0, '0, 16'sd32767, C_ONE, C_ONE, -C_ONE, 32'sd7);
    add_req(32'sd100, 32'sd200, 16'sd16385, C_ONE, -C_ONE, 32'sd3, -32'sd5);
    add_req(-32'sd100, 32'sd200, -16'sd16385, C_ONE, -C_ONE, 32'sd3, -32'sd5);
    add_req('0, '0, 16'sd1, C_MAX, '0, '0, C_MAX);
    add_req('0, '0, -16'sd1, C_MIN, '0, '0, C_MIN);
    // saturation toward both rails
    add_req(C_MAX, C_MAX, '0, C_MAX, C_MAX, C_ONE, C_ONE);
    add_req(C_MIN, C_MIN, '0, C_MIN, C_MIN, -C_ONE, -C_ONE);
    add_req(C_MAX, C_MIN, 16'sd8192, C_MAX, C_MIN, C_MIN, C_MAX);
    add_req(C_MIN, C_MAX, -16'sd8192, C_MIN, C_MAX, C_MAX, C_MIN);
    add_req(C_MAX, C_MAX, -16'sd32768, C_MIN, C_MIN, C_MAX, C_MAX);
    add_req(-32'sd1, -32'sd1, 16'sd32767, -32'sd1, -32'sd1, 32'sd1, 32'sd1);
    add_req(C_MAX, C_MIN, 16'sd4096, '0, '0, '0, '0);
    add_req(32'sh0123_4567, -32'sh0765_4321, -16'sd12000, 32'sh0002_8000, -32'sh0001_4000,
            32'sh0010_0000, 32'sh0000_8000);
    add_req(32'sd1, -32'sd1, 16'sh5555, 32'sh0AAA_AAAA, -32'sh0555_5555,
            32'sh0000_FFFF, -32'sh0000_FFFF);
    for (k = 0; k < RANDOM_REQS; k++)
      add_req(rand_coord(), rand_coord(), rand_heading(), rand_coord(), rand_coord(),
              rand_coord(), rand_coord());
    total_reqs = pending_q.size();

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_q.size() != 0 || expected_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
